>>> rtl/core/matrix_inverse_3x3_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse
// Shared property wrappers, clocked on aclk, idle in reset.
// ---------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// implication checked at every edge out of reset
`define MI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define MI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/minv_pkg.sv
// ---------------------------------------------------------------------------
// minv_pkg
// Widths and constants shared by the matrix inverse pipeline.
// ---------------------------------------------------------------------------
package minv_pkg;
    localparam int ENTRY_W   = 32;
    localparam int FRAC_DEF  = 16;
    localparam int COF_W     = 66;
    localparam int DET_W     = 98;
    localparam int NUM_W     = 114;
    localparam int NUM_LANES = 9;
    localparam logic [ENTRY_W-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [ENTRY_W-1:0] Q_NEG_MAX = 32'h8000_0000;
endpackage

>>> rtl/core/minv_lane.sv
// ---------------------------------------------------------------------------
// minv_lane
// Restoring divider lane: one quotient bit per stage, fully pipelined,
// then sign restore and saturation to 32 bits.
// ---------------------------------------------------------------------------
module minv_lane import minv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [COF_W-2:0]          num_mag,
    input  logic                      neg_in,
    input  logic [DET_W-1:0]          den,
    output logic signed [ENTRY_W-1:0] q_out,
    output logic                      sat_out
);
    localparam int NB = COF_W - 1 + 2 * FRAC_BITS;
    localparam int RW = DET_W + 1;

    logic [NB-1:0] n_reg [NB+1];
    logic [RW-1:0] r_reg [NB+1];
    logic [DET_W-1:0] d_reg [NB+1];
    logic neg_reg [NB+1];
    logic [NB-1:0] n_next [NB+1];
    logic [RW-1:0] r_next [NB+1];

    always_comb begin
        n_next[0] = {num_mag, {(2*FRAC_BITS){1'b0}}};
        r_next[0] = '0;
        for (int i = 1; i <= NB; i++) begin
            logic [RW-1:0] t;
            t = {r_reg[i-1][RW-2:0], n_reg[i-1][NB-1]};
            if (t >= {1'b0, d_reg[i-1]}) begin
                r_next[i] = t - {1'b0, d_reg[i-1]};
                n_next[i] = {n_reg[i-1][NB-2:0], 1'b1};
            end else begin
                r_next[i] = t;
                n_next[i] = {n_reg[i-1][NB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg[0] <= n_next[0];
            r_reg[0] <= r_next[0];
            d_reg[0] <= den;
            neg_reg[0] <= neg_in;
            for (int i = 1; i <= NB; i++) begin
                n_reg[i] <= n_next[i];
                r_reg[i] <= r_next[i];
                d_reg[i] <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    logic [NB-1:0] q;
    logic hi_nz;
    assign q = n_reg[NB];
    assign hi_nz = |q[NB-1:ENTRY_W];

    always_comb begin
        if (neg_reg[NB]) begin
            if (hi_nz || q[ENTRY_W-1:0] > Q_NEG_MAX) begin
                q_out = Q_NEG_MAX; sat_out = 1'b1;
            end else begin
                q_out = -q[ENTRY_W-1:0]; sat_out = 1'b0;
            end
        end else begin
            if (hi_nz || q[ENTRY_W-1:0] > Q_POS_MAX) begin
                q_out = Q_POS_MAX; sat_out = 1'b1;
            end else begin
                q_out = q[ENTRY_W-1:0]; sat_out = 1'b0;
            end
        end
    end
endmodule

>>> rtl/core/minv_front.sv
// ---------------------------------------------------------------------------
// minv_front
// Cofactors and determinant from registered products; the final determinant sum is combinational.
// ---------------------------------------------------------------------------
module minv_front import minv_pkg::*; (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic signed [ENTRY_W-1:0] m [9],
    output logic signed [COF_W-1:0]   cof [9],
    output logic signed [DET_W-1:0]   det
);
    localparam int I0 [9] = '{4,2,1,5,0,2,3,1,0};
    localparam int J0 [9] = '{8,7,5,6,8,3,7,6,4};
    localparam int I1 [9] = '{5,1,2,3,2,0,4,0,1};
    localparam int J1 [9] = '{7,8,4,8,6,5,6,7,3};
    localparam int HALF_W = COF_W / 2;

    logic signed [ENTRY_W-1:0] m_reg [9];
    logic signed [2*ENTRY_W-1:0] pa_reg [9], pb_reg [9];
    logic signed [COF_W-1:0] c_reg [9];
    logic signed [ENTRY_W-1:0] a0_reg [3];
    logic signed [ENTRY_W-1:0] a1_reg [3];
    // cofactor split in two halves, each half times the row 0 entry
    logic signed [HALF_W+ENTRY_W:0] pl_reg [3];
    logic signed [HALF_W+ENTRY_W-1:0] ph_reg [3];
    logic signed [COF_W+ENTRY_W-1:0] t_reg [3];
    logic signed [COF_W-1:0] c2_reg [9];
    logic signed [COF_W-1:0] c3_reg [9];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg <= m;
            for (int k = 0; k < 9; k++) begin
                pa_reg[k] <= m_reg[I0[k]] * m_reg[J0[k]];
                pb_reg[k] <= m_reg[I1[k]] * m_reg[J1[k]];
                c_reg[k]  <= COF_W'(pa_reg[k]) - COF_W'(pb_reg[k]);
            end
            a0_reg[0] <= m_reg[0]; a0_reg[1] <= m_reg[1]; a0_reg[2] <= m_reg[2];
            a1_reg <= a0_reg;
            for (int j = 0; j < 3; j++) begin
                pl_reg[j] <= $signed({1'b0, c_reg[3*j][HALF_W-1:0]}) * a1_reg[j];
                ph_reg[j] <= $signed(c_reg[3*j][COF_W-1:HALF_W]) * a1_reg[j];
                t_reg[j]  <= {ph_reg[j], {HALF_W{1'b0}}}
                           + (COF_W+ENTRY_W)'(pl_reg[j]);
            end
            c2_reg <= c_reg;
            c3_reg <= c2_reg;
        end
    end

    assign cof = c3_reg;
    assign det = DET_W'(t_reg[0]) + DET_W'(t_reg[1]) + DET_W'(t_reg[2]);
endmodule

>>> rtl/core/matrix_inverse_3x3.sv
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 Q16.16 inverse by adjugate over determinant, nine divider lanes.
//
//  channel | dir | handshake
//  s_      | in  | s_valid / s_ready, nine entries
//  m_      | out | m_valid / m_ready, nine entries + flags
//
// One matrix per cycle; most of the pipe depth lies in the
// bit-per-stage divider lanes. The whole pipe advances when the output
// register is free or taken; a stalled beat freezes every stage.
// Reset clears the valid bits only.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3 import minv_pkg::*; #(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [ENTRY_W-1:0] s_in_r0c0, s_in_r0c1, s_in_r0c2,
    input  logic signed [ENTRY_W-1:0] s_in_r1c0, s_in_r1c1, s_in_r1c2,
    input  logic signed [ENTRY_W-1:0] s_in_r2c0, s_in_r2c1, s_in_r2c2,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [ENTRY_W-1:0] m_out_r0c0, m_out_r0c1, m_out_r0c2,
    output logic signed [ENTRY_W-1:0] m_out_r1c0, m_out_r1c1, m_out_r1c2,
    output logic signed [ENTRY_W-1:0] m_out_r2c0, m_out_r2c1, m_out_r2c2,
    output logic m_singular,
    output logic m_saturated
);
`include "matrix_inverse_3x3_macros.svh"

    localparam int DEPTH = 6 + COF_W - 1 + 2 * FRAC_BITS + 1;

    logic adv;
    logic [DEPTH-1:0] v_reg;
    logic signed [ENTRY_W-1:0] m_in [9];
    logic signed [COF_W-1:0] cof [9];
    logic signed [DET_W-1:0] det;
    logic [DET_W-1:0] dmag;
    logic signed [ENTRY_W-1:0] q [9];
    logic sat [9];
    logic sing_reg [DEPTH-6];
    logic sing_next;

    assign adv = !v_reg[DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_in = '{s_in_r0c0, s_in_r0c1, s_in_r0c2, s_in_r1c0, s_in_r1c1,
                    s_in_r1c2, s_in_r2c0, s_in_r2c1, s_in_r2c2};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[DEPTH-2:0], s_valid};
        end
    end

    minv_front u_front (.aclk(aclk), .adv(adv), .m(m_in), .cof(cof), .det(det));

    assign dmag = det[DET_W-1] ? -det : det;
    assign sing_next = (det == '0);

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        logic [COF_W-1:0] ca;
        assign ca = cof[k][COF_W-1] ? -cof[k] : cof[k];
        minv_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk(aclk), .adv(adv), .num_mag(ca[COF_W-2:0]),
            .neg_in(cof[k][COF_W-1] ^ det[DET_W-1]),
            .den(sing_next ? DET_W'(1) : dmag), .q_out(q[k]), .sat_out(sat[k]));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sing_reg[0] <= sing_next;
            for (int i = 1; i < DEPTH - 6; i++) sing_reg[i] <= sing_reg[i-1];
        end
    end

    logic sng;
    logic signed [ENTRY_W-1:0] o [9];
    logic any_sat;
    assign sng = sing_reg[DEPTH-7];
    always_comb begin
        any_sat = 1'b0;
        for (int k = 0; k < 9; k++) begin
            o[k] = sng ? '0 : q[k];
            any_sat = any_sat | sat[k];
        end
    end

    logic signed [ENTRY_W-1:0] o_reg [9];
    logic sg_reg, st_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            o_reg  <= o;
            sg_reg <= sng;
            st_reg <= any_sat && !sng;
        end
    end

    assign m_valid = v_reg[DEPTH-1];
    assign {m_out_r0c0, m_out_r0c1, m_out_r0c2} = {o_reg[0], o_reg[1], o_reg[2]};
    assign {m_out_r1c0, m_out_r1c1, m_out_r1c2} = {o_reg[3], o_reg[4], o_reg[5]};
    assign {m_out_r2c0, m_out_r2c1, m_out_r2c2} = {o_reg[6], o_reg[7], o_reg[8]};
    assign m_singular = sg_reg;
    assign m_saturated = st_reg;

    `MI_ASSERT_IMP(a_stall_ready, m_valid && !m_ready, !s_ready, "ready while output stalled")
    `MI_ASSERT_IMP(a_flags_excl, m_valid, !(m_singular && m_saturated), "singular and saturated")
    `MI_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_out_r0c0), "stalled beat changed")
    `MI_ASSERT_IMP(a_sing_zero, m_valid && m_singular, m_out_r1c1 == '0, "singular result not zero")
endmodule

>>> verif/matrix_inverse_3x3_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Streams 3x3 Q16.16 matrices through the inverse, first from a directed
// table and then at random, with bursty input and a stalling output. Every
// result beat is checked field by field, against the listed result for
// typed table rows, else an exact wide-integer adjugate/determinant model.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3_tb import minv_pkg::*;;

    localparam int FRAC       = FRAC_DEF;
    localparam int N_RANDOM   = 700;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN      = 5 + 65 + 2 * FRAC + 20;
    localparam int CYCLE_CAP  = 200000;

    typedef logic signed [ENTRY_W-1:0] mat_t [NUM_LANES];
    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic signed [ENTRY_W-1:0] e [NUM_LANES];
        logic singular;
        logic saturated;
    } inv_t;

    typedef struct {
        mat_t m;
        bit   typed;
        inv_t r;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [ENTRY_W-1:0] s_in [NUM_LANES];
    logic signed [ENTRY_W-1:0] m_out [NUM_LANES];
    logic m_singular, m_saturated;

    inv_t  inverse_q[$];
    row_t  table_q[$];
    int    n_acc = 0;
    int    n_err = 0;
    int    n_cyc = 0;
    bit    cur_typed;
    inv_t  cur_exp;

    always #5 aclk = ~aclk;

    matrix_inverse_3x3 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_r0c0(s_in[0]), .s_in_r0c1(s_in[1]), .s_in_r0c2(s_in[2]),
        .s_in_r1c0(s_in[3]), .s_in_r1c1(s_in[4]), .s_in_r1c2(s_in[5]),
        .s_in_r2c0(s_in[6]), .s_in_r2c1(s_in[7]), .s_in_r2c2(s_in[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_r0c0(m_out[0]), .m_out_r0c1(m_out[1]), .m_out_r0c2(m_out[2]),
        .m_out_r1c0(m_out[3]), .m_out_r1c1(m_out[4]), .m_out_r1c2(m_out[5]),
        .m_out_r2c0(m_out[6]), .m_out_r2c1(m_out[7]), .m_out_r2c2(m_out[8]),
        .m_singular(m_singular), .m_saturated(m_saturated)
    );

    function automatic wide_t minor2(logic signed [31:0] a, logic signed [31:0] b,
                                     logic signed [31:0] c, logic signed [31:0] d);
        return wide_t'(a) * wide_t'(b) - wide_t'(c) * wide_t'(d);
    endfunction

    function automatic inv_t invert(mat_t a);
        wide_t adj [NUM_LANES];
        wide_t det, dmag, q;
        bit neg;
        inv_t r;
        adj[0] = minor2(a[4], a[8], a[5], a[7]);
        adj[1] = minor2(a[2], a[7], a[1], a[8]);
        adj[2] = minor2(a[1], a[5], a[2], a[4]);
        adj[3] = minor2(a[5], a[6], a[3], a[8]);
        adj[4] = minor2(a[0], a[8], a[2], a[6]);
        adj[5] = minor2(a[2], a[3], a[0], a[5]);
        adj[6] = minor2(a[3], a[7], a[4], a[6]);
        adj[7] = minor2(a[1], a[6], a[0], a[7]);
        adj[8] = minor2(a[0], a[4], a[1], a[3]);
        det = adj[0] * wide_t'(a[0]) + adj[3] * wide_t'(a[1]) + adj[6] * wide_t'(a[2]);
        r.singular  = (det == 0);
        r.saturated = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) r.e[i] = '0;
        if (r.singular) return r;
        dmag = (det < 0) ? -det : det;
        for (int i = 0; i < NUM_LANES; i++) begin
            neg = (adj[i] < 0) != (det < 0);
            q = (((adj[i] < 0) ? -adj[i] : adj[i]) <<< (2 * FRAC)) / dmag;
            if (neg) begin
                if (q > 64'sh8000_0000) begin
                    r.e[i] = Q_NEG_MAX;
                    r.saturated = 1'b1;
                end else begin
                    r.e[i] = -q[31:0];
                end
            end else begin
                if (q > 64'sh7FFF_FFFF) begin
                    r.e[i] = Q_POS_MAX;
                    r.saturated = 1'b1;
                end else begin
                    r.e[i] = q[31:0];
                end
            end
        end
        return r;
    endfunction

    function automatic mat_t diag3(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z);
        mat_t m;
        foreach (m[i]) m[i] = '0;
        m[0] = x;
        m[4] = y;
        m[8] = z;
        return m;
    endfunction

    function automatic mat_t fill9(logic signed [31:0] v);
        mat_t m;
        foreach (m[i]) m[i] = v;
        return m;
    endfunction

    function automatic inv_t diag_inv(logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z, logic sat);
        inv_t r;
        foreach (r.e[i]) r.e[i] = '0;
        r.e[0] = x;
        r.e[4] = y;
        r.e[8] = z;
        r.singular  = 1'b0;
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic signed [31:0] small_q();
        return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endfunction

    function automatic mat_t random_matrix();
        mat_t m;
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        foreach (m[i]) begin
            case (kind) inside
                [0:3]:   m[i] = $urandom;
                8:       m[i] = $signed($urandom_range(0, 6)) - 3;
                default: m[i] = small_q();
            endcase
        end
        if (kind == 7) begin
            k = $urandom_range(1, 3);
            for (int c = 0; c < 3; c++) m[6 + c] = (k == 3) ? 0 : m[c] * k;
        end else if (kind == 9) begin
            m[0] = m[0] + 8 * 65536;
            m[4] = m[4] - 8 * 65536;
            m[8] = m[8] + 8 * 65536;
        end
        return m;
    endfunction

    function automatic void add_row(mat_t m, bit typed, inv_t r);
        row_t t;
        t.m = m;
        t.typed = typed;
        t.r = r;
        table_q.push_back(t);
    endfunction

    // beat accounting and result checks
    always @(posedge aclk) begin
        inv_t want;
        mat_t in_now;
        if (aresetn) begin
            n_cyc++;
            if (n_cyc > CYCLE_CAP) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (s_valid && s_ready) begin
                foreach (in_now[i]) in_now[i] = s_in[i];
                inverse_q.push_back(cur_typed ? cur_exp : invert(in_now));
                n_acc++;
            end
            if (m_valid && m_ready) begin
                if (inverse_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    n_err++;
                end else begin
                    want = inverse_q.pop_front();
                    for (int i = 0; i < NUM_LANES; i++) begin
                        if (m_out[i] !== want.e[i]) begin
                            $display("%0t: out_r%0dc%0d expected %h actual %h",
                                     $time, i / 3, i % 3, want.e[i], m_out[i]);
                            n_err++;
                        end
                    end
                    if (m_singular !== want.singular) begin
                        $display("%0t: singular expected %b actual %b",
                                 $time, want.singular, m_singular);
                        n_err++;
                    end
                    if (m_saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.saturated, m_saturated);
                        n_err++;
                    end
                end
            end
        end
    end

    // output back-pressure, with one long hold to fill the pipe
    initial begin
        int mode;
        int len;
        bit held;
        held = 0;
        m_ready = 1'b0;
        forever begin
            if (!held && n_acc >= HOLD_AFTER) begin
                m_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                held = 1;
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(10, 60);
            repeat (len) begin
                @(negedge aclk);
                m_ready = (mode == 0) ? 1'b1 :
                          (mode == 1) ? ($urandom_range(0, 3) != 0) :
                                        ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic send_matrix(mat_t m, bit typed, inv_t r, inout int burst);
        int target;
        if (burst == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst = $urandom_range(1, 24);
        end
        foreach (m[i]) s_in[i] = m[i];
        cur_typed = typed;
        cur_exp = r;
        s_valid = 1'b1;
        target = n_acc + 1;
        do @(negedge aclk); while (n_acc != target);
        burst--;
    endtask

    initial begin
        inv_t none;
        inv_t sing;
        int burst;
        int waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        cur_typed = 1'b0;
        foreach (s_in[i]) s_in[i] = '0;
        none = diag_inv(0, 0, 0, 0);
        sing = none;
        sing.singular = 1'b1;

        add_row(diag3(32'sh1_0000, 32'sh1_0000, 32'sh1_0000), 1,
                diag_inv(32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 0));
        add_row(diag3(-32'sh1_0000, -32'sh1_0000, -32'sh1_0000), 1,
                diag_inv(-32'sh1_0000, -32'sh1_0000, -32'sh1_0000, 0));
        add_row(diag3(32'sh2_0000, 32'sh2_0000, 32'sh2_0000), 1,
                diag_inv(32'sh8000, 32'sh8000, 32'sh8000, 0));
        add_row(fill9(0), 1, sing);
        add_row(fill9(Q_POS_MAX), 1, sing);
        add_row(fill9(Q_NEG_MAX), 1, sing);
        add_row(diag3(Q_POS_MAX, Q_POS_MAX, Q_POS_MAX), 1, diag_inv(2, 2, 2, 0));
        add_row(diag3(Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX), 1, diag_inv(-2, -2, -2, 0));
        add_row(diag3(1, 1, 1), 1, diag_inv(Q_POS_MAX, Q_POS_MAX, Q_POS_MAX, 1));
        add_row(diag3(-1, 1, 1), 1, diag_inv(Q_NEG_MAX, Q_POS_MAX, Q_POS_MAX, 1));
        add_row('{1, 2, 3, 1, 2, 3, 7, 8, 9}, 1, sing);
        add_row('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                  32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555,
                  32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA}, 0, none);
        add_row('{0, -32'sh1_0000, 0, 32'sh1_0000, 0, 0, 0, 0, 32'sh1_0000}, 0, none);
        add_row('{Q_POS_MAX, Q_NEG_MAX, 0, 0, Q_POS_MAX, Q_NEG_MAX,
                  Q_NEG_MAX, 0, Q_POS_MAX}, 0, none);
        add_row('{Q_NEG_MAX, 1, -1, -1, Q_NEG_MAX, 1, 1, -1, Q_NEG_MAX}, 0, none);
        add_row('{32'sh3_0000, 32'sh1_0000, 0, 32'sh1_0000, 32'sh2_0000,
                  32'sh1_0000, 0, 32'sh1_0000, 32'sh4_0000}, 0, none);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        burst = $urandom_range(1, 24);
        foreach (table_q[k]) send_matrix(table_q[k].m, table_q[k].typed, table_q[k].r, burst);
        for (int k = 0; k < N_RANDOM; k++) send_matrix(random_matrix(), 0, none, burst);
        s_valid = 1'b0;

        waited = 0;
        while (inverse_q.size() != 0 && waited < CYCLE_CAP) begin
            @(negedge aclk);
            waited++;
        end
        repeat (DRAIN) @(negedge aclk);
        if (n_err == 0 && inverse_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> matrix_inverse_3x3.f
+incdir+rtl/core
rtl/core/minv_pkg.sv
rtl/core/minv_lane.sv
rtl/core/minv_front.sv
rtl/core/matrix_inverse_3x3.sv
verif/matrix_inverse_3x3_tb.sv
